FILE: rtl/gdnw_pkg.sv
// Shared constants, month tables and stage types for the Gregorian day counter.
`timescale 1ns / 1ps
`default_nettype none

package gdnw_pkg;

  // Result status codes.
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_YEAR  = 2'd1;
  localparam logic [1:0] ERR_MONTH = 2'd2;
  localparam logic [1:0] ERR_DAY   = 2'd3;

  // Reciprocal of 100 for 16-bit dividends: q = (x * RECIP_100) >> RECIP_SHIFT.
  // The rounding error of the constant times the largest dividend stays below
  // 2^RECIP_SHIFT, so the quotient is exact over the whole 16-bit range.
  localparam logic [16:0] RECIP_100   = 17'd83887;
  localparam int          RECIP_SHIFT = 23;

  localparam int YEAR_W  = 16;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DOY_W   = 9;
  localparam int COUNT_W = 25;
  localparam int Q100_W  = 10;

  // Length of each month in a common year; zero for a month number that is not valid.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the first of each month in a common year.
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [Q100_W-1:0]  q100;
  } st1_t;

  typedef struct packed {
    logic [1:0]         err;
    logic               leap;
    logic [DOY_W-1:0]   doy;
    logic [YEAR_W-1:0]  py;
    logic [COUNT_W-1:0] py365;
    logic [Q100_W-1:0]  qpy;
  } st2_t;

  typedef struct packed {
    logic [1:0]         err;
    logic               leap;
    logic [DOY_W-1:0]   doy;
    logic [COUNT_W-1:0] count;
  } st3_t;

  typedef struct packed {
    logic [2:0]         weekday;
    logic [COUNT_W-1:0] count;
    logic [DOY_W-1:0]   doy;
    logic               leap;
    logic [1:0]         error_code;
    logic               date_ok;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/gregorian_day_number_weekday.sv
// Top level of the Gregorian date checker, day counter and weekday calculator.
`timescale 1ns / 1ps
`default_nettype none

// This block takes one proleptic Gregorian date per request on the slave stream
// and returns one result per request on the master stream, in order. A date is
// valid when the year is at least 1, the month is 1 to 12 and the day lies within
// the month, with February at 29 in a leap year. Checks run year first, then
// month, then day, and the first failing check sets the error code; an invalid
// date returns zeros in the leap flag, day of year, day count and weekday. For a
// valid date the day count starts at 1 on 0001-01-01 and the weekday is that
// count mod 7 with 0 meaning Sunday. The block is a four-stage pipeline: the
// first stage divides the year by 100 with a reciprocal multiply, the second
// settles the leap rule, the checks, the day of year and the year-times-365
// product, the third sums the day count, and the fourth folds the count mod 7
// into the output register. A new request can be taken every cycle while the
// master side does not stall. The first stage loads at the accepting edge, and
// each request then moves through the second, third and fourth stage registers
// before m_tvalid rises. A stall on the master side backs up stage by stage
// without losing or repeating anything.
module gregorian_day_number_weekday
  import gdnw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // Fields from bit 0: cal_year[15:0], cal_month[19:16], cal_day[24:20], zero fill.
  input  wire logic [31:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // Fields from bit 0: date_ok[0], error_code[2:1], leap_flag[3], day_of_year[12:4],
  // day_count[37:13], weekday[40:38], zero fill.
  output logic [47:0]      m_tdata
);

  // Each stage moves forward when it is empty or the stage after it moves.
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4 || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign m_tvalid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Stage 1: year / 100 by reciprocal multiply, exact for every 16-bit year.
  st1_t                      st1, st1_next;
  logic [YEAR_W+16:0]        q100_prod;

  always_comb begin
    st1_next.year  = s_tdata[15:0];
    st1_next.month = s_tdata[19:16];
    st1_next.day   = s_tdata[24:20];
    q100_prod      = st1_next.year * RECIP_100;
    st1_next.q100  = q100_prod[RECIP_SHIFT +: Q100_W];
  end

  always_ff @(posedge clk) begin
    if (rdy1) st1 <= st1_next;
  end

  // Stage 2: leap rule, validity checks, day of year and (year - 1) * 365.
  st2_t                 st2, st2_next;
  logic [YEAR_W:0]      q100_x100;
  logic [YEAR_W-1:0]    rem100;
  logic                 cent;
  logic                 leap;
  logic [4:0]           mlen;

  always_comb begin
    q100_x100 = {{(YEAR_W+1-Q100_W){1'b0}}, st1.q100} * 7'd100;
    rem100    = st1.year - q100_x100[YEAR_W-1:0];
    cent      = (rem100 == '0);
    // Divisible by 4 and not by 100, or divisible by 400.
    leap      = (st1.year[1:0] == 2'b00) && (!cent || (st1.q100[1:0] == 2'b00));
    mlen      = month_len(st1.month);
    if ((st1.month == 4'd2) && leap) mlen = 5'd29;

    if (st1.year == '0) begin
      st2_next.err = ERR_YEAR;
    end else if (mlen == 5'd0) begin
      st2_next.err = ERR_MONTH;
    end else if ((st1.day == '0) || (st1.day > mlen)) begin
      st2_next.err = ERR_DAY;
    end else begin
      st2_next.err = ERR_NONE;
    end

    st2_next.leap  = leap;
    st2_next.doy   = days_before(st1.month) + {4'd0, st1.day}
                     + {8'd0, (leap && (st1.month > 4'd2))};
    st2_next.py    = st1.year - 16'd1;
    st2_next.py365 = {{(COUNT_W-YEAR_W){1'b0}}, st2_next.py} * 9'd365;
    // (year - 1) / 100 is one less than year / 100 exactly when year is a century.
    st2_next.qpy   = st1.q100 - {{(Q100_W-1){1'b0}}, cent};
  end

  always_ff @(posedge clk) begin
    if (rdy2) st2 <= st2_next;
  end

  // Stage 3: day count; invalid dates carry zeros from here on.
  st3_t st3, st3_next;

  always_comb begin
    st3_next.err = st2.err;
    if (st2.err == ERR_NONE) begin
      st3_next.leap  = st2.leap;
      st3_next.doy   = st2.doy;
      st3_next.count = st2.py365
                       + {{(COUNT_W-YEAR_W+2){1'b0}}, st2.py[YEAR_W-1:2]}
                       + {{(COUNT_W-Q100_W+2){1'b0}}, st2.qpy[Q100_W-1:2]}
                       - {{(COUNT_W-Q100_W){1'b0}}, st2.qpy}
                       + {{(COUNT_W-DOY_W){1'b0}}, st2.doy};
    end else begin
      st3_next.leap  = 1'b0;
      st3_next.doy   = '0;
      st3_next.count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) st3 <= st3_next;
  end

  // Stage 4: count mod 7 by summing octal digits, since 8 is 1 mod 7.
  res_t       res, res_next;
  logic [26:0] cnt_ext;
  logic [5:0]  dsum;
  logic [3:0]  fold1;
  logic [2:0]  fold2;

  always_comb begin
    cnt_ext = {2'b00, st3.count};
    dsum    = '0;
    for (int i = 0; i < 9; i++) begin
      dsum = dsum + {3'd0, cnt_ext[3*i +: 3]};
    end
    fold1 = {1'b0, dsum[5:3]} + {1'b0, dsum[2:0]};
    fold2 = {2'b00, fold1[3]} + fold1[2:0];

    res_next.weekday    = (fold2 == 3'd7) ? 3'd0 : fold2;
    res_next.count      = st3.count;
    res_next.doy        = st3.doy;
    res_next.leap       = st3.leap;
    res_next.error_code = st3.err;
    res_next.date_ok    = (st3.err == ERR_NONE);
  end

  always_ff @(posedge clk) begin
    if (rdy4) res <= res_next;
  end

  assign m_tdata = {7'd0, res};

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking stream testbench for the Gregorian date checker and day counter.
`timescale 1ns / 1ps

// The bench sends dates as requests on the slave stream and checks every result
// that comes back on the master stream against its own calendar arithmetic. It
// runs in two parts. First comes a short table of directed dates: the extremes of
// the year range, every error code, faults that occur together, and the leap
// year rules at century boundaries. Then about 800 random dates follow. Most of
// them are well formed, some fall at month and century boundaries, and the rest
// are raw field values or days just past the end of a month. Both sides idle at
// random. Once, the receiver holds off for a long stretch while the sender keeps
// pushing, so the pipeline backs up into its input. Once, the sender waits until
// the pipeline has fully drained.
module tb_top;
  import gdnw_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 11;
  localparam int RANDOM_DATES    = 800;
  localparam int HOLD_OFF_AT     = 200;
  localparam int DRAIN_AT        = 500;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 16;
  localparam int CYCLE_LIMIT     = 400000;

  // One result, unpacked into its fields.
  typedef struct packed {
    logic         ok;
    logic [1:0]   err;
    logic         leap;
    logic [8:0]   doy;
    logic [24:0]  count;
    logic [2:0]   wd;
  } date_result_t;

  // One row of the directed table. When "typed" is set, the expected result is
  // written out by hand. Otherwise the calendar arithmetic below supplies it.
  typedef struct {
    logic [15:0]  year;
    logic [3:0]   month;
    logic [4:0]   day;
    bit           typed;
    date_result_t want;
  } date_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;

  date_result_t awaited_dates[$];
  date_row_t    directed_rows[$];

  int  mismatch_count;
  int  results_checked;
  int  valid_sent;
  int  invalid_sent;
  int  input_stall_cycles;
  int  cycle_count;
  bit  hold_off_wanted;

  gregorian_day_number_weekday uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Calendar arithmetic used for prediction.
  // ---------------------------------------------------------------------------

  // A year is a leap year when it divides by 4 but not by 100, or divides by 400.
  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Callers pass only months 1 to 12.
  function automatic int unsigned month_length(input int unsigned m, input bit leap);
    case (m)
      2:            return leap ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  // The year is checked first, then the month, then the day, and the first
  // failing check decides the code. An invalid date leaves every other field at
  // zero. The day count treats 0001-01-01 as day 1, and a count of 0 mod 7
  // means Sunday.
  function automatic date_result_t calendar_result(input logic [15:0] year,
                                                   input logic [3:0]  month,
                                                   input logic [4:0]  day);
    date_result_t r;
    bit           leap;
    int unsigned  mlen;
    int unsigned  doy;
    int unsigned  py;
    int unsigned  total;
    r = '0;
    if (year == 16'd0) begin
      r.err = ERR_YEAR;
    end else if (month < 4'd1 || month > 4'd12) begin
      r.err = ERR_MONTH;
    end else begin
      leap = leap_year(year);
      mlen = month_length(month, leap);
      if (day < 5'd1 || day > mlen) begin
        r.err = ERR_DAY;
      end else begin
        doy = day;
        for (int k = 1; k < month; k++) doy += month_length(k, leap);
        py    = year - 1;
        total = py * 365 + py / 4 - py / 100 + py / 400 + doy;
        r.ok    = 1'b1;
        r.err   = ERR_NONE;
        r.leap  = leap;
        r.doy   = doy[8:0];
        r.count = total[24:0];
        r.wd    = 3'(total % 7);
      end
    end
    return r;
  endfunction

  function automatic date_result_t fault(input logic [1:0] code);
    date_result_t r;
    r = '0;
    r.err = code;
    return r;
  endfunction

  function automatic date_result_t good_date(input logic leap, input logic [8:0] doy,
                                             input logic [24:0] total, input logic [2:0] wd);
    date_result_t r;
    r.ok    = 1'b1;
    r.err   = ERR_NONE;
    r.leap  = leap;
    r.doy   = doy;
    r.count = total;
    r.wd    = wd;
    return r;
  endfunction

  // Most gaps are zero or short, and a few are long.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic add_row(input logic [15:0] year, input logic [3:0] month,
                         input logic [4:0] day, input bit typed, input date_result_t want);
    date_row_t row;
    row.year  = year;
    row.month = month;
    row.day   = day;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // The caller must enter this task right after a rising edge. It returns at
  // the edge where the request is accepted, or at the end of the gap that
  // follows. It drives s_tvalid at most once per time step.
  task automatic offer_date(input logic [15:0] year, input logic [3:0] month,
                            input logic [4:0] day, input bit typed,
                            input date_result_t want, input bit no_gap);
    date_result_t expected;
    int           gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, day, month, year};
    do @(posedge clk); while (!s_tready);
    expected = typed ? want : calendar_result(year, month, day);
    awaited_dates.push_back(expected);
    if (expected.ok) valid_sent++;
    else invalid_sent++;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The random mix is mostly well formed: uniform years, century and small
  // years, and days biased toward the end of the month. The rest is days one
  // past the end of the month, and raw field values with year 0 common enough
  // to appear often.
  task automatic random_date(output logic [15:0] y, output logic [3:0] m,
                             output logic [4:0] d);
    int unsigned pick;
    int unsigned yy;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      y = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
      m = 4'($urandom);
      d = 5'($urandom);
    end else begin
      if (pick < 40) yy = 100 * $urandom_range(1, 655) + $urandom_range(0, 1);
      else if (pick < 50) yy = $urandom_range(1, 500);
      else yy = $urandom_range(1, 65535);
      y   = yy[15:0];
      m   = 4'($urandom_range(1, 12));
      len = month_length(m, leap_year(yy));
      if (pick < 30) d = 5'(len + 1);
      else if ($urandom_range(0, 3) == 0) d = 5'(len);
      else d = 5'($urandom_range(1, len));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    int          burst_left;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The first and last days of the range have known counts and weekdays.
    add_row(16'd1,     4'd1,  5'd1,  1, good_date(1'b0, 9'd1, 25'd1, 3'd1));
    add_row(16'd65535, 4'd12, 5'd31, 1, good_date(1'b0, 9'd365, 25'd23936166, 3'd2));
    // Year 0 is rejected no matter what else is wrong.
    add_row(16'd0,     4'd1,  5'd1,  1, fault(ERR_YEAR));
    add_row(16'd0,     4'd15, 5'd31, 1, fault(ERR_YEAR));
    add_row(16'd0,     4'd0,  5'd0,  1, fault(ERR_YEAR));
    // Bad months, including a bad day that the month check masks.
    add_row(16'd1,     4'd0,  5'd1,  1, fault(ERR_MONTH));
    add_row(16'd1,     4'd0,  5'd0,  1, fault(ERR_MONTH));
    add_row(16'd2024,  4'd13, 5'd10, 1, fault(ERR_MONTH));
    add_row(16'd65535, 4'd15, 5'd31, 1, fault(ERR_MONTH));
    // Bad days: day 0, past a 30-day month, and February past its length.
    add_row(16'd2023,  4'd6,  5'd0,  1, fault(ERR_DAY));
    add_row(16'd2023,  4'd4,  5'd31, 1, fault(ERR_DAY));
    add_row(16'd1900,  4'd2,  5'd29, 1, fault(ERR_DAY));
    add_row(16'd2023,  4'd2,  5'd29, 1, fault(ERR_DAY));
    add_row(16'd2024,  4'd2,  5'd30, 1, fault(ERR_DAY));
    // Leap rules and the extra day after February, checked by prediction.
    add_row(16'd2000,  4'd2,  5'd29, 0, '0);
    add_row(16'd2024,  4'd2,  5'd29, 0, '0);
    add_row(16'd2000,  4'd12, 5'd31, 0, '0);
    add_row(16'd2024,  4'd3,  5'd1,  0, '0);
    add_row(16'd1900,  4'd3,  5'd1,  0, '0);
    add_row(16'd400,   4'd12, 5'd31, 0, '0);
    add_row(16'd1,     4'd12, 5'd31, 0, '0);
    add_row(16'd65535, 4'd1,  5'd31, 0, '0);
    add_row(16'd32768, 4'd8,  5'd16, 0, '0);
    add_row(16'd2023,  4'd12, 5'd1,  0, '0);

    foreach (directed_rows[i]) begin
      offer_date(directed_rows[i].year, directed_rows[i].month, directed_rows[i].day,
                 directed_rows[i].typed, directed_rows[i].want, 1'b0);
    end

    burst_left = 0;
    for (int i = 0; i < RANDOM_DATES; i++) begin
      // Ask the receiver for its long hold-off, then push without gaps so that
      // the pipeline fills and the input stalls.
      if (i == HOLD_OFF_AT) begin
        hold_off_wanted = 1'b1;
        burst_left = 60;
      end
      // Pause the sender until every expected result has come back.
      if (i == DRAIN_AT) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited_dates.size() != 0) @(posedge clk);
      end
      // Stretches without any idling from the sender.
      if (burst_left == 0 && $urandom_range(0, 99) < 3) burst_left = $urandom_range(10, 40);
      random_date(y, m, d);
      offer_date(y, m, d, 1'b0, '0, burst_left > 0);
      if (burst_left > 0) burst_left--;
    end
    s_tvalid <= 1'b0;

    while (awaited_dates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb_top summary: %0d dates sent (%0d valid, %0d rejected), %0d results compared",
             valid_sent + invalid_sent, valid_sent, invalid_sent, results_checked);
    $display("tb_top summary: input held back on %0d cycles, %0d field mismatches",
             input_stall_cycles, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver. It alternates runs of ready with random stalls. It also performs
  // one long hold-off, counted here, when the sender asks for it.
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_wanted) begin
        hold_off_wanted = 1'b0;
        m_tready <= 1'b0;
        for (int c = 0; c < HOLD_OFF_CYCLES; c++) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 80 : 8)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking. Each accepted result is compared with the oldest
  // expectation, one field at a time.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    date_result_t want;
    date_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.ok    = m_tdata[0];
      got.err   = m_tdata[2:1];
      got.leap  = m_tdata[3];
      got.doy   = m_tdata[12:4];
      got.count = m_tdata[37:13];
      got.wd    = m_tdata[40:38];
      if (awaited_dates.size() == 0) begin
        $display("%0t ns: result with no request pending, expected none, got %h",
                 $time, m_tdata);
        mismatch_count++;
      end else begin
        want = awaited_dates.pop_front();
        check_field("date_ok",     want.ok,    got.ok);
        check_field("error_code",  want.err,   got.err);
        check_field("leap_flag",   want.leap,  got.leap);
        check_field("day_of_year", want.doy,   got.doy);
        check_field("day_count",   want.count, got.count);
        check_field("weekday",     want.wd,    got.wd);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && !s_tready) input_stall_cycles++;
  end

  // Watchdog: a run that has not finished by the limit has hung.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: timeout after %0d cycles, %0d results still pending",
             cycle_count, awaited_dates.size());
    $display("tb_top: errors");
    $finish;
  end

endmodule
